[sv/vrt_pkg.sv]
// Package for the voxel ray traversal block: widths, fixed-point constants,
// result and request codes, and small helper functions. No dependencies.
`default_nettype none

package vrt_pkg;

   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 16;
   localparam int AXES       = 3;
   localparam int AXIS_W     = 2;
   localparam int T_W        = 32;
   localparam logic [T_W-1:0] T_SAT = '1;

   // reciprocal: 2^(FRAC_BITS+14) / |dir|, dir magnitude at most 2^15
   localparam int DIR_W  = 16;
   localparam int QW     = FRAC_BITS + 15;
   localparam int CNT_W  = $clog2(QW + 1);
   localparam int DIST_W = 17;
   localparam int PROD_W = DIST_W + T_W;

   localparam int LIMIT_W = 24;
   localparam int LIM_CMP_W = (T_W + 16 > LIMIT_W + FRAC_BITS) ? T_W + 16
                                                             : LIMIT_W + FRAC_BITS;

   localparam int CODE_W    = 8;
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_AIR   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WATER = 1'd1;

   localparam logic REQ_START  = 1'b0;
   localparam logic REQ_ANSWER = 1'b1;

   typedef enum logic [1:0] {
      KIND_QUERY = 2'd0,
      KIND_HIT   = 2'd1,
      KIND_MISS  = 2'd2
   } result_kind_type;

   typedef logic [COORD_BITS-1:0] coord_type;

   // integer part of a Q16.16 origin, sign-extended and wrapped to COORD_BITS
   function automatic coord_type origin_cell(input logic [31:0] raw);
      logic [31:0] ip;
      ip = {{16{raw[31]}}, raw[31:16]};
      return ip[COORD_BITS-1:0];
   endfunction

   function automatic logic signed [15:0] coord_out(input coord_type c);
      logic [31:0] ext;
      ext = 32'($signed(c));
      return ext[15:0];
   endfunction

   function automatic logic [T_W-1:0] sat_add(input logic [T_W-1:0] a,
                                              input logic [T_W-1:0] b);
      logic [T_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[T_W] ? T_SAT : s[T_W-1:0];
   endfunction

endpackage

`default_nettype wire

[sv/vrt_if.sv]
// Request and response channel interfaces of the voxel ray traversal block.
// Depends on vrt_pkg for field widths.
`default_nettype none

interface vrt_req_if;
   logic                                valid;
   logic                                ready;
   logic                                req_type;
   logic signed [31:0]                  origin_x;
   logic signed [31:0]                  origin_y;
   logic signed [31:0]                  origin_z;
   logic signed [vrt_pkg::DIR_W-1:0]    dir_x;
   logic signed [vrt_pkg::DIR_W-1:0]    dir_y;
   logic signed [vrt_pkg::DIR_W-1:0]    dir_z;
   logic [vrt_pkg::LIMIT_W-1:0]         max_distance;
   logic [vrt_pkg::CODE_W-1:0]          block_type;

   modport source (output valid, req_type, origin_x, origin_y, origin_z,
                   dir_x, dir_y, dir_z, max_distance, block_type,
                   input ready);
   modport sink   (input valid, req_type, origin_x, origin_y, origin_z,
                   dir_x, dir_y, dir_z, max_distance, block_type,
                   output ready);
endinterface

interface vrt_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         result_kind;
   logic signed [15:0] cell_x;
   logic signed [15:0] cell_y;
   logic signed [15:0] cell_z;
   logic signed [15:0] prev_x;
   logic signed [15:0] prev_y;
   logic signed [15:0] prev_z;

   modport source (output valid, result_kind, cell_x, cell_y, cell_z,
                   prev_x, prev_y, prev_z, input ready);
   modport sink   (input valid, result_kind, cell_x, cell_y, cell_z,
                   prev_x, prev_y, prev_z, output ready);
endinterface

`default_nettype wire

[sv/vrt_div.sv]
// Radix-2 restoring divider: 2^(FRAC_BITS+14) / divisor, one quotient bit
// per cycle. Depends on vrt_pkg.
`default_nettype none

module vrt_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [vrt_pkg::DIR_W-1:0]  divisor,
   output logic                            done,
   output logic [vrt_pkg::QW-1:0]          quotient
);
   import vrt_pkg::*;

   localparam logic [QW-1:0] DIVIDEND = {1'b1, {(QW-1){1'b0}}};

   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [QW-1:0]     q_ff;
   logic [DIR_W-1:0]  rem_ff;
   logic [DIR_W-1:0]  dvs_ff;

   logic [DIR_W:0]    trial;
   logic              qbit;
   logic [DIR_W:0]    diff;

   always_comb begin
      trial = {rem_ff, q_ff[QW-1]};
      qbit  = trial >= {1'b0, dvs_ff};
      diff  = trial - {1'b0, dvs_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         if (start) begin
            busy_ff <= 1'b1;
            done_ff <= 1'b0;
            cnt_ff  <= CNT_W'(QW);
            q_ff    <= DIVIDEND;
            rem_ff  <= '0;
            dvs_ff  <= divisor;
         end else if (busy_ff) begin
            // remainder stays below the divisor, so it fits DIR_W bits
            rem_ff  <= qbit ? diff[DIR_W-1:0] : trial[DIR_W-1:0];
            q_ff    <= {q_ff[QW-2:0], qbit};
            cnt_ff  <= cnt_ff - CNT_W'(1);
            busy_ff <= cnt_ff != CNT_W'(1);
            done_ff <= cnt_ff == CNT_W'(1);
         end else begin
            done_ff <= 1'b0;
         end
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

`ifndef ASSERT_OFF
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !start) else $error("divider restarted while busy");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("divider done longer than one cycle");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(done_ff) |-> $past(busy_ff)) else $error("done without a division");
`endif

endmodule

`default_nettype wire

[sv/voxel_ray_traversal.sv]
// Voxel ray traversal (3D grid walk) top level: sequencer, ray state, output
// register. Depends on vrt_pkg, vrt_if and vrt_div.
`default_nettype none

// A start transaction sets up the ray: per axis, a nonzero direction takes a
// setup step, one pass of the shared bit-serial divider, then the delta load,
// boundary multiply and boundary store; a zero axis takes the setup step only.
// Once every axis is set up, the query for the origin cell appears as soon as
// the response register is free. An answer transaction is accepted and its
// query, hit or miss is presented on the next cycle. Answers while no ray is
// active produce nothing. The request side is ready only when the sequencer is
// idle and the response register is empty or being drained in the same cycle.
module voxel_ray_traversal (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_we,
   input  wire logic [vrt_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [vrt_pkg::CODE_W-1:0]    csr_data,
   vrt_req_if.sink                            req_ch,
   vrt_rsp_if.source                          rsp_ch
);
   import vrt_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_AXIS, S_DIV, S_LOAD, S_MUL, S_BND, S_FIN
   } state_type;

   state_type          state_ff;
   logic [AXIS_W-1:0]  axis_ff;

   logic [CODE_W-1:0]  air_ff;
   logic [CODE_W-1:0]  water_ff;

   logic               active_ff;
   coord_type          cell_ff  [AXES];
   coord_type          prev_ff  [AXES];
   logic [AXES-1:0]    sign_ff;
   logic [T_W-1:0]     delta_ff [AXES];
   logic [T_W-1:0]     bound_ff [AXES];
   logic [LIMIT_W-1:0] limit_ff;
   logic [15:0]        frac_ff  [AXES];
   logic [DIR_W-1:0]   mag_ff   [AXES];
   logic [PROD_W-1:0]  prod_ff;

   logic               rsp_valid_ff;
   result_kind_type    rsp_kind_ff;
   logic signed [15:0] rsp_cell_ff [AXES];
   logic signed [15:0] rsp_prev_ff [AXES];

   // start decode
   logic [31:0]        org     [AXES];
   logic [DIR_W-1:0]   dir     [AXES];
   logic [DIR_W-1:0]   dir_mag [AXES];
   logic [AXES-1:0]    dir_pos;

   // answer step
   logic               out_free;
   logic               accept;
   logic               rsp_load;
   logic               solid;
   logic [AXIS_W-1:0]  sel;
   logic [T_W-1:0]     t_sel;
   logic [T_W-1:0]     t_next;
   coord_type          cell_step;
   coord_type          cell_nx [AXES];
   logic               miss;

   // setup datapath
   logic               div_start;
   logic               div_done;
   logic [QW-1:0]      div_q;
   logic [T_W-1:0]     q_sat;
   logic [DIST_W-1:0]  face_dist;
   logic [T_W-1:0]     bnd_sat;

   vrt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (mag_ff[axis_ff]),
      .done     (div_done),
      .quotient (div_q)
   );

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE) && out_free;
   assign accept       = req_ch.valid && req_ch.ready;
   // answer on a live ray, or the origin query once setup is done
   assign rsp_load     = (accept && req_ch.req_type == REQ_ANSWER && active_ff)
                         || ((state_ff == S_FIN) && out_free);

   always_comb begin
      org[0] = req_ch.origin_x;
      org[1] = req_ch.origin_y;
      org[2] = req_ch.origin_z;
      dir[0] = req_ch.dir_x;
      dir[1] = req_ch.dir_y;
      dir[2] = req_ch.dir_z;
      for (int a = 0; a < AXES; a++) begin
         dir_mag[a] = dir[a][DIR_W-1] ? (DIR_W'(0) - dir[a]) : dir[a];
         dir_pos[a] = !dir[a][DIR_W-1] && (dir[a] != '0);
      end
   end

   always_comb begin
      solid = (req_ch.block_type != air_ff) && (req_ch.block_type != water_ff);
      if (bound_ff[0] <= bound_ff[1] && bound_ff[0] <= bound_ff[2]) begin
         sel = AXIS_W'(0);
      end else if (bound_ff[1] <= bound_ff[2]) begin
         sel = AXIS_W'(1);
      end else begin
         sel = AXIS_W'(2);
      end
      t_sel     = bound_ff[sel];
      t_next    = sat_add(t_sel, delta_ff[sel]);
      cell_step = sign_ff[sel] ? cell_ff[sel] + COORD_BITS'(1)
                               : cell_ff[sel] - COORD_BITS'(1);
      for (int a = 0; a < AXES; a++) begin
         cell_nx[a] = (AXIS_W'(a) == sel) ? cell_step : cell_ff[a];
      end
      miss = LIM_CMP_W'({t_sel, 16'b0}) > LIM_CMP_W'({limit_ff, {FRAC_BITS{1'b0}}});
   end

   always_comb begin
      div_start = (state_ff == S_AXIS) && (mag_ff[axis_ff] != '0);
      q_sat     = (64'(div_q) > 64'(T_SAT)) ? T_SAT : T_W'(div_q);
      face_dist = sign_ff[axis_ff] ? (DIST_W'(17'h10000) - DIST_W'(frac_ff[axis_ff]))
                                   : DIST_W'(frac_ff[axis_ff]);
      bnd_sat   = (prod_ff[PROD_W-1:16] > (PROD_W-16)'(T_SAT)) ? T_SAT
                                                               : prod_ff[T_W+15:16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         air_ff   <= '0;
         water_ff <= CODE_W'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_AIR:   air_ff   <= csr_data;
            CSR_WATER: water_ff <= csr_data;
            default:   ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         axis_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_load || (rsp_valid_ff && !rsp_ch.ready);
         unique case (state_ff)
            S_IDLE: begin
               if (accept && req_ch.req_type == REQ_START) begin
                  for (int a = 0; a < AXES; a++) begin
                     cell_ff[a] <= origin_cell(org[a]);
                     prev_ff[a] <= origin_cell(org[a]);
                     frac_ff[a] <= org[a][15:0];
                     mag_ff[a]  <= dir_mag[a];
                  end
                  sign_ff   <= dir_pos;
                  limit_ff  <= req_ch.max_distance;
                  active_ff <= 1'b1;
                  axis_ff   <= '0;
                  state_ff  <= S_AXIS;
               end else if (accept && active_ff) begin
                  if (solid) begin
                     active_ff   <= 1'b0;
                     rsp_kind_ff <= KIND_HIT;
                     for (int a = 0; a < AXES; a++) begin
                        rsp_cell_ff[a] <= coord_out(cell_ff[a]);
                        rsp_prev_ff[a] <= coord_out(prev_ff[a]);
                     end
                  end else begin
                     for (int a = 0; a < AXES; a++) begin
                        prev_ff[a] <= cell_ff[a];
                        cell_ff[a] <= cell_nx[a];
                        rsp_prev_ff[a] <= '0;
                        rsp_cell_ff[a] <= miss ? 16'sd0 : coord_out(cell_nx[a]);
                     end
                     bound_ff[sel] <= t_next;
                     if (miss) begin
                        active_ff   <= 1'b0;
                        rsp_kind_ff <= KIND_MISS;
                     end else begin
                        rsp_kind_ff <= KIND_QUERY;
                     end
                  end
               end
            end
            S_AXIS: begin
               if (mag_ff[axis_ff] == '0) begin
                  // zero component: bound saturates, picked only on a tie
                  delta_ff[axis_ff] <= T_SAT;
                  bound_ff[axis_ff] <= T_SAT;
                  if (axis_ff == AXIS_W'(AXES - 1)) begin
                     state_ff <= S_FIN;
                  end else begin
                     axis_ff <= axis_ff + AXIS_W'(1);
                  end
               end else begin
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (div_done) begin
                  state_ff <= S_LOAD;
               end
            end
            S_LOAD: begin
               delta_ff[axis_ff] <= q_sat;
               state_ff          <= S_MUL;
            end
            S_MUL: begin
               prod_ff  <= PROD_W'(face_dist) * PROD_W'(delta_ff[axis_ff]);
               state_ff <= S_BND;
            end
            S_BND: begin
               bound_ff[axis_ff] <= bnd_sat;
               if (axis_ff == AXIS_W'(AXES - 1)) begin
                  state_ff <= S_FIN;
               end else begin
                  axis_ff  <= axis_ff + AXIS_W'(1);
                  state_ff <= S_AXIS;
               end
            end
            S_FIN: begin
               if (out_free) begin
                  rsp_kind_ff  <= KIND_QUERY;
                  for (int a = 0; a < AXES; a++) begin
                     rsp_cell_ff[a] <= coord_out(cell_ff[a]);
                     rsp_prev_ff[a] <= '0;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.result_kind = rsp_kind_ff;
   assign rsp_ch.cell_x      = rsp_cell_ff[0];
   assign rsp_ch.cell_y      = rsp_cell_ff[1];
   assign rsp_ch.cell_z      = rsp_cell_ff[2];
   assign rsp_ch.prev_x      = rsp_prev_ff[0];
   assign rsp_ch.prev_y      = rsp_prev_ff[1];
   assign rsp_ch.prev_z      = rsp_prev_ff[2];

`ifndef ASSERT_OFF
   a_start_setup: assert property (@(posedge clock) disable iff (reset)
      accept && req_ch.req_type == REQ_START |=> active_ff && state_ff == S_AXIS)
      else $error("start transaction did not begin ray setup");
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == KIND_MISS |->
         rsp_cell_ff[0] == 16'sd0 && rsp_cell_ff[1] == 16'sd0 && rsp_cell_ff[2] == 16'sd0)
      else $error("miss with nonzero cell");
   a_query_prev: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff != KIND_HIT |->
         rsp_prev_ff[0] == 16'sd0 && rsp_prev_ff[1] == 16'sd0 && rsp_prev_ff[2] == 16'sd0)
      else $error("prev cell set on a non-hit result");
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV)
      else $error("divider finished outside the wait state");
   a_end_inactive: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) && rsp_kind_ff != KIND_QUERY |-> !active_ff)
      else $error("ray still active after hit or miss");
`endif

endmodule

`default_nettype wire
